>>> src/mlp_pkg.sv
// Package with the shared constants, item types and fixed-point helpers of the perceptron.
package mlp_pkg;

	localparam int INPUT_COUNT      = 2;
	localparam int HIDDEN_COUNT     = 3;
	localparam int FRAC_BITS        = 12;
	localparam int HID_WEIGHT_COUNT = INPUT_COUNT * HIDDEN_COUNT;
	localparam int ALL_WEIGHTS      = HID_WEIGHT_COUNT + HIDDEN_COUNT;
	localparam int ADDR_W           = $clog2(ALL_WEIGHTS);
	localparam int HALF_STEP_BITS   = FRAC_BITS - 1;
	localparam int LR_RESET         = 410;

	localparam logic [1:0] OP_INFER = 2'd0;
	localparam logic [1:0] OP_TRAIN = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [12:0] ONE_Q = 13'(1 << FRAC_BITS);

	localparam logic [12:0] SIG_TABLE [17] = '{
		13'd2048, 13'd2550, 13'd2994, 13'd3349, 13'd3608, 13'd3785, 13'd3902, 13'd3976,
		13'd4022, 13'd4051, 13'd4069, 13'd4079, 13'd4086, 13'd4090, 13'd4092, 13'd4094,
		13'd4095
	};

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] feature_a;
		logic signed [15:0] feature_b;
		logic [12:0]        target_value;
		logic [3:0]         weight_index;
		logic signed [15:0] weight_value;
	} in_item_t;

	typedef struct packed {
		logic [12:0]        network_output;
		logic [11:0]        loss;
		logic signed [15:0] weight_read;
	} out_item_t;

	function automatic logic [12:0] sigmoid_fx(input logic signed [20:0] z);
		logic [20:0] a;
		logic [3:0]  idx;
		logic [10:0] frac;
		logic [12:0] lo;
		logic [12:0] hi;
		logic [12:0] v;
		logic [23:0] m;
		a = z[20] ? 21'(-z) : 21'(z);
		idx = a[HALF_STEP_BITS +: 4];
		frac = a[HALF_STEP_BITS-1:0];
		lo = SIG_TABLE[{1'b0, idx}];
		hi = SIG_TABLE[{1'b0, idx} + 5'd1];
		m = 24'(hi - lo) * 24'(frac);
		if (a >= 21'(16 << HALF_STEP_BITS)) begin
			v = SIG_TABLE[16];
		end else begin
			v = lo + 13'(m >> HALF_STEP_BITS);
		end
		return z[20] ? 13'(ONE_Q - v) : v;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
		if (v > 25'sd32767) begin
			return 16'sh7fff;
		end else if (v < -25'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

>>> src/mlp_if.sv
// Handshake interfaces for the sample and result channels.
interface mlp_in_if;
	logic              valid;
	logic              ready;
	mlp_pkg::in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mlp_out_if;
	logic               valid;
	logic               ready;
	mlp_pkg::out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> src/mlp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mlp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> src/mlp_2_3_1_backprop_step.sv
// Top level: 2-3-1 sigmoid perceptron with inference, one SGD step per train item, and weight write and read.
// The result register is loaded from the completion state; the next item is accepted once the
// state machine is back in idle. An item runs state by state, since all products share the
// single multiplier and all weights sit in the one weight RAM.
// One item is in work at a time; a finished item waits until the result register is free.
// Asynchronous reset sets the learning rate to 410 and makes every weight read as zero.
module mlp_2_3_1_backprop_step (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [12:0]  cfg_wdata,
	mlp_in_if.sink       sample,
	mlp_out_if.source    result
);
	import mlp_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_RDW  = 5'd1;
	localparam logic [4:0] ST_H0   = 5'd2;
	localparam logic [4:0] ST_H1   = 5'd3;
	localparam logic [4:0] ST_H2   = 5'd4;
	localparam logic [4:0] ST_H3   = 5'd5;
	localparam logic [4:0] ST_H4   = 5'd6;
	localparam logic [4:0] ST_H5   = 5'd7;
	localparam logic [4:0] ST_H6   = 5'd8;
	localparam logic [4:0] ST_Y0   = 5'd9;
	localparam logic [4:0] ST_Y1   = 5'd10;
	localparam logic [4:0] ST_L0   = 5'd11;
	localparam logic [4:0] ST_L1   = 5'd12;
	localparam logic [4:0] ST_D0   = 5'd13;
	localparam logic [4:0] ST_D1   = 5'd14;
	localparam logic [4:0] ST_D2   = 5'd15;
	localparam logic [4:0] ST_D3   = 5'd16;
	localparam logic [4:0] ST_O0   = 5'd17;
	localparam logic [4:0] ST_O1   = 5'd18;
	localparam logic [4:0] ST_O2   = 5'd19;
	localparam logic [4:0] ST_G0   = 5'd20;
	localparam logic [4:0] ST_G1   = 5'd21;
	localparam logic [4:0] ST_G2   = 5'd22;
	localparam logic [4:0] ST_G3   = 5'd23;
	localparam logic [4:0] ST_G4   = 5'd24;
	localparam logic [4:0] ST_G5   = 5'd25;
	localparam logic [4:0] ST_G6   = 5'd26;
	localparam logic [4:0] ST_DONE = 5'd27;

	localparam logic [1:0] LAST_HIDDEN = 2'(HIDDEN_COUNT - 1);

	logic [4:0]          state_q;
	logic [12:0]         lr_q;
	logic [1:0]          op_q;
	logic signed [15:0]  x_q [INPUT_COUNT];
	logic [12:0]         tgt_q;
	logic                widx_ok_q;
	logic [1:0]          i_q;
	logic                j_q;
	logic signed [47:0]  prod_q;
	logic signed [32:0]  acc_q;
	logic signed [32:0]  oacc_q;
	logic signed [20:0]  z_q;
	logic signed [15:0]  wo_q;
	logic [12:0]         h_q [HIDDEN_COUNT];
	logic [12:0]         y_q;
	logic signed [13:0]  err_q;
	logic [11:0]         loss_q;
	logic [10:0]         slope_q;
	logic signed [11:0]  dout_q;
	logic signed [12:0]  dh_q;
	logic signed [15:0]  wread_q;
	logic [ALL_WEIGHTS-1:0] wvalid_q;
	logic                rvalid_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic                accept;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [15:0]         ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [15:0]         ram_rdata;
	logic signed [15:0]  rdat;
	logic signed [30:0]  mul_a;
	logic signed [16:0]  mul_b;
	logic signed [15:0]  wsat;
	logic [ADDR_W-1:0]   out_addr;
	logic [ADDR_W-1:0]   hid_addr;
	logic                out_free;
	logic [12:0]         h_cur;

	assign accept = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.payload = out_q;
	assign rdat = rvalid_q ? signed'(ram_rdata) : 16'sd0;
	assign h_cur = h_q[i_q];
	assign out_addr = ADDR_W'(HID_WEIGHT_COUNT) + ADDR_W'(i_q);
	assign hid_addr = ADDR_W'(i_q) + (j_q ? ADDR_W'(HIDDEN_COUNT) : ADDR_W'(0));
	assign wsat = sat16(25'(rdat) + 25'(prod_q >>> (2 * FRAC_BITS)));

	mlp_ram #(.WIDTH(16), .DEPTH(ALL_WEIGHTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = out_addr;
		ram_wdata = wsat;
		ram_re = 1'b0;
		ram_raddr = out_addr;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IDLE: begin
				ram_waddr = sample.payload.weight_index[ADDR_W-1:0];
				ram_wdata = sample.payload.weight_value;
				ram_raddr = sample.payload.weight_index[ADDR_W-1:0];
				ram_we = accept && sample.payload.op == OP_WRITE
					&& sample.payload.weight_index < 4'(ALL_WEIGHTS);
				ram_re = accept && sample.payload.op == OP_READ;
			end
			ST_H0: begin
				ram_re = 1'b1;
				ram_raddr = ADDR_W'(i_q);
			end
			ST_H1: begin
				ram_re = 1'b1;
				ram_raddr = ADDR_W'(i_q) + ADDR_W'(HIDDEN_COUNT);
				mul_a = 31'(x_q[0]);
				mul_b = 17'(rdat);
			end
			ST_H2: begin
				ram_re = 1'b1;
				mul_a = 31'(x_q[1]);
				mul_b = 17'(rdat);
			end
			ST_H5: begin
				mul_a = 31'(h_cur);
				mul_b = 17'(wo_q);
			end
			ST_L0: begin
				mul_a = 31'(err_q);
				mul_b = 17'(err_q);
			end
			ST_D0: begin
				mul_a = 31'(y_q);
				mul_b = 17'(ONE_Q - y_q);
			end
			ST_D2: begin
				mul_a = 31'(err_q);
				mul_b = 17'(slope_q);
			end
			ST_O0: begin
				ram_re = 1'b1;
				mul_a = 31'(lr_q);
				mul_b = 17'(h_cur);
			end
			ST_O1: begin
				mul_a = prod_q[30:0];
				mul_b = 17'(dout_q);
			end
			ST_O2: begin
				ram_we = 1'b1;
			end
			ST_G0: begin
				ram_re = 1'b1;
				mul_a = 31'(h_cur);
				mul_b = 17'(ONE_Q - h_cur);
			end
			ST_G1: begin
				mul_a = 31'(dout_q);
				mul_b = 17'(rdat);
			end
			ST_G2: begin
				mul_a = 31'(prod_q >>> FRAC_BITS);
				mul_b = 17'(slope_q);
			end
			ST_G4: begin
				ram_re = 1'b1;
				ram_raddr = hid_addr;
				mul_a = 31'(lr_q);
				mul_b = 17'(x_q[j_q]);
			end
			ST_G5: begin
				mul_a = prod_q[30:0];
				mul_b = 17'(dh_q);
			end
			ST_G6: begin
				ram_we = 1'b1;
				ram_waddr = hid_addr;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (ram_re) begin
			rvalid_q <= wvalid_q[ram_raddr];
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q <= sample.payload.op;
					x_q[0] <= sample.payload.feature_a;
					x_q[1] <= sample.payload.feature_b;
					tgt_q <= (sample.payload.target_value > ONE_Q) ? ONE_Q
						: sample.payload.target_value;
					widx_ok_q <= sample.payload.weight_index < 4'(ALL_WEIGHTS);
					oacc_q <= '0;
					y_q <= '0;
					loss_q <= '0;
					wread_q <= '0;
				end
			end
			ST_RDW: wread_q <= widx_ok_q ? rdat : 16'sd0;
			ST_H2: acc_q <= prod_q[32:0];
			ST_H3: begin
				wo_q <= rdat;
				z_q <= 21'((acc_q + prod_q[32:0]) >>> FRAC_BITS);
			end
			ST_H4: h_q[i_q] <= sigmoid_fx(z_q);
			ST_H6: oacc_q <= oacc_q + prod_q[32:0];
			ST_Y0: z_q <= 21'(oacc_q >>> FRAC_BITS);
			ST_Y1: begin
				y_q <= sigmoid_fx(z_q);
				err_q <= 14'(tgt_q) - 14'(sigmoid_fx(z_q));
			end
			ST_L1: loss_q <= (prod_q >>> (FRAC_BITS + 1)) > 48'sd4095 ? 12'd4095
				: prod_q[FRAC_BITS+1 +: 12];
			ST_D1: slope_q <= prod_q[FRAC_BITS +: 11];
			ST_D3: dout_q <= 12'(prod_q >>> FRAC_BITS);
			ST_G1: slope_q <= prod_q[FRAC_BITS +: 11];
			ST_G3: dh_q <= 13'(prod_q >>> FRAC_BITS);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lr_q <= 13'(LR_RESET);
			wvalid_q <= '0;
			i_q <= '0;
			j_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_we) begin
				lr_q <= cfg_wdata;
			end
			if (ram_we) begin
				wvalid_q[ram_waddr] <= 1'b1;
			end
			if (out_valid_q && result.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						i_q <= '0;
						j_q <= 1'b0;
						case (sample.payload.op)
							OP_WRITE: state_q <= ST_DONE;
							OP_READ:  state_q <= ST_RDW;
							default:  state_q <= ST_H0;
						endcase
					end
				end
				ST_RDW: state_q <= ST_DONE;
				ST_H0:  state_q <= ST_H1;
				ST_H1:  state_q <= ST_H2;
				ST_H2:  state_q <= ST_H3;
				ST_H3:  state_q <= ST_H4;
				ST_H4:  state_q <= ST_H5;
				ST_H5:  state_q <= ST_H6;
				ST_H6: begin
					if (i_q == LAST_HIDDEN) begin
						i_q <= '0;
						state_q <= ST_Y0;
					end else begin
						i_q <= i_q + 2'd1;
						state_q <= ST_H0;
					end
				end
				ST_Y0: state_q <= ST_Y1;
				ST_Y1: state_q <= ST_L0;
				ST_L0: state_q <= ST_L1;
				ST_L1: state_q <= (op_q == OP_TRAIN) ? ST_D0 : ST_DONE;
				ST_D0: state_q <= ST_D1;
				ST_D1: state_q <= ST_D2;
				ST_D2: state_q <= ST_D3;
				ST_D3: state_q <= ST_O0;
				ST_O0: state_q <= ST_O1;
				ST_O1: state_q <= ST_O2;
				ST_O2: begin
					if (i_q == LAST_HIDDEN) begin
						i_q <= '0;
						state_q <= ST_G0;
					end else begin
						i_q <= i_q + 2'd1;
						state_q <= ST_O0;
					end
				end
				ST_G0: state_q <= ST_G1;
				ST_G1: state_q <= ST_G2;
				ST_G2: state_q <= ST_G3;
				ST_G3: begin
					j_q <= 1'b0;
					state_q <= ST_G4;
				end
				ST_G4: state_q <= ST_G5;
				ST_G5: state_q <= ST_G6;
				ST_G6: begin
					if (!j_q) begin
						j_q <= 1'b1;
						state_q <= ST_G4;
					end else if (i_q == LAST_HIDDEN) begin
						state_q <= ST_DONE;
					end else begin
						i_q <= i_q + 2'd1;
						state_q <= ST_G0;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q.network_output <= y_q;
						out_q.loss <= loss_q;
						out_q.weight_read <= wread_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ram_waddr < ADDR_W'(ALL_WEIGHTS))
		else $error("Weight RAM written beyond its last entry.");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_DONE))
		else $error("Result raised outside the completion state.");

	a_output_update_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_O2 |-> ram_we && ram_waddr >= ADDR_W'(HID_WEIGHT_COUNT))
		else $error("Output weight update aimed at a hidden weight.");

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("An accepted item did not start work.");
endmodule

>>> dv/mlp_tb_if.sv
`timescale 1ns / 1ps
// Testbench package with the clock timing.
package mlp_tb_pkg;
	localparam int HALF_PERIOD_NS = 2;
endpackage

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for the 2-3-1 perceptron: directed and random items, checked against a predictor.
module tb;
	import mlp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [12:0] cfg_wdata = '0;
	int send_idle = 0;
	int take_idle = 0;
	int failures = 0;

	mlp_in_if sample ();
	mlp_out_if result ();

	mlp_2_3_1_backprop_step u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.sample(sample.sink), .result(result.source)
	);

	always begin
		#(mlp_tb_pkg::HALF_PERIOD_NS) clk = 1'b1;
		#(mlp_tb_pkg::HALF_PERIOD_NS) clk = 1'b0;
	end

	logic [12:0] model_rate;
	logic signed [15:0] model_hidden [HID_WEIGHT_COUNT];
	logic signed [15:0] model_output [HIDDEN_COUNT];
	out_item_t expected_results [$];

	function automatic longint floor_div(input longint v, input int n);
		return v >>> n;
	endfunction

	function automatic longint squash(input longint z);
		longint a, v, lo, hi, fr;
		int idx;
		a = z < 0 ? -z : z;
		if (a >= (longint'(16) << HALF_STEP_BITS)) begin
			v = SIG_TABLE[16];
		end else begin
			idx = int'(a >> HALF_STEP_BITS);
			fr = a - (longint'(idx) << HALF_STEP_BITS);
			lo = SIG_TABLE[idx];
			hi = SIG_TABLE[idx + 1];
			v = lo + (((hi - lo) * fr) >>> HALF_STEP_BITS);
		end
		return z < 0 ? 4096 - v : v;
	endfunction

	function automatic longint slope(input longint s);
		return floor_div(s * (4096 - s), FRAC_BITS);
	endfunction

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end
		if (v < -32768) begin
			return -16'sd32768;
		end
		return 16'(v);
	endfunction

	function automatic out_item_t predict_step(input in_item_t it);
		out_item_t r;
		longint x [2];
		longint h [HIDDEN_COUNT];
		longint tgt, acc, s, y, err, ls, d_out, d_h, stp;
		int k;
		r = '0;
		x[0] = it.feature_a;
		x[1] = it.feature_b;
		if (it.op == OP_WRITE) begin
			if (it.weight_index < HID_WEIGHT_COUNT) begin
				model_hidden[it.weight_index] = it.weight_value;
			end else if (it.weight_index < ALL_WEIGHTS) begin
				model_output[it.weight_index - HID_WEIGHT_COUNT] = it.weight_value;
			end
			return r;
		end
		if (it.op == OP_READ) begin
			if (it.weight_index < HID_WEIGHT_COUNT) begin
				r.weight_read = model_hidden[it.weight_index];
			end else if (it.weight_index < ALL_WEIGHTS) begin
				r.weight_read = model_output[it.weight_index - HID_WEIGHT_COUNT];
			end
			return r;
		end
		tgt = it.target_value > 4096 ? 4096 : it.target_value;
		acc = 0;
		for (int i = 0; i < HIDDEN_COUNT; i++) begin
			s = 0;
			for (int j = 0; j < INPUT_COUNT; j++) begin
				s += x[j] * model_hidden[j * HIDDEN_COUNT + i];
			end
			h[i] = squash(floor_div(s, FRAC_BITS));
			acc += h[i] * model_output[i];
		end
		y = squash(floor_div(acc, FRAC_BITS));
		err = tgt - y;
		ls = (err * err) >>> (FRAC_BITS + 1);
		if (ls > 4095) begin
			ls = 4095;
		end
		r.network_output = 13'(y);
		r.loss = 12'(ls);
		if (it.op != OP_TRAIN) begin
			return r;
		end
		d_out = floor_div(err * slope(y), FRAC_BITS);
		for (int i = 0; i < HIDDEN_COUNT; i++) begin
			stp = floor_div(longint'(model_rate) * h[i] * d_out, 2 * FRAC_BITS);
			model_output[i] = clip16(model_output[i] + stp);
		end
		for (int i = 0; i < HIDDEN_COUNT; i++) begin
			d_h = floor_div(d_out * model_output[i], FRAC_BITS);
			d_h = floor_div(d_h * slope(h[i]), FRAC_BITS);
			for (int j = 0; j < INPUT_COUNT; j++) begin
				k = j * HIDDEN_COUNT + i;
				stp = floor_div(longint'(model_rate) * x[j] * d_h, 2 * FRAC_BITS);
				model_hidden[k] = clip16(model_hidden[k] + stp);
			end
		end
		return r;
	endfunction

	task automatic send_item(input in_item_t it);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			@(negedge clk);
		end
		sample.payload = it;
		sample.valid = 1'b1;
		do @(posedge clk); while (!sample.ready);
		expected_results.push_back(predict_step(it));
		@(negedge clk);
		sample.valid = 1'b0;
	endtask

	always @(negedge clk) begin
		result.ready <= arst_n && !(take_idle > 0 && $urandom_range(99) < take_idle);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no expectation waiting");
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (result.payload.network_output !== want.network_output) begin
					$error("network_output expected %0d got %0d",
						want.network_output, result.payload.network_output);
					failures++;
				end
				if (result.payload.loss !== want.loss) begin
					$error("loss expected %0d got %0d", want.loss, result.payload.loss);
					failures++;
				end
				if (result.payload.weight_read !== want.weight_read) begin
					$error("weight_read expected %0d got %0d",
						want.weight_read, result.payload.weight_read);
					failures++;
				end
			end
		end
	end

	task automatic drain;
		while (expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (100) @(negedge clk);
	endtask

	task automatic set_rate(input logic [12:0] v);
		drain();
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		model_rate = v;
	endtask

	function automatic in_item_t make_item(input logic [1:0] op);
		in_item_t it;
		it.op = op;
		it.feature_a = 16'($urandom);
		it.feature_b = 16'($urandom);
		if ($urandom_range(3) != 0) begin
			it.feature_a = 16'($signed($urandom_range(16383)) - 8192);
			it.feature_b = 16'($signed($urandom_range(16383)) - 8192);
		end
		it.target_value = $urandom_range(9) == 0 ? 13'($urandom) : 13'($urandom_range(4096));
		it.weight_index = $urandom_range(7) == 0 ? 4'($urandom) : 4'($urandom_range(8));
		it.weight_value = $urandom_range(3) == 0 ? 16'($urandom)
			: 16'($signed($urandom_range(16383)) - 8192);
		return it;
	endfunction

	task automatic test_weight_access;
		in_item_t it;
		for (int k = 0; k < 16; k++) begin
			it = make_item(OP_WRITE);
			it.weight_index = 4'(k);
			it.weight_value = k[0] ? 16'sh7fff : -16'sd32768;
			send_item(it);
			it.op = OP_READ;
			send_item(it);
		end
	endtask

	task automatic test_directed_passes;
		in_item_t it;
		it = make_item(OP_INFER);
		it.feature_a = 16'sh7fff;
		it.feature_b = -16'sd32768;
		it.target_value = 13'h1fff;
		send_item(it);
		it.op = OP_TRAIN;
		send_item(it);
		it.feature_a = 16'sd0;
		it.target_value = 13'd0;
		send_item(it);
	endtask

	task automatic test_random(input int count);
		in_item_t it;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0: it = make_item(OP_WRITE);
				1: it = make_item(OP_READ);
				2, 3: it = make_item(OP_INFER);
				default: it = make_item(OP_TRAIN);
			endcase
			send_item(it);
		end
	endtask

	initial begin
		sample.valid = 1'b0;
		sample.payload = '0;
		model_rate = 13'(LR_RESET);
		for (int k = 0; k < HID_WEIGHT_COUNT; k++) begin
			model_hidden[k] = '0;
		end
		for (int k = 0; k < HIDDEN_COUNT; k++) begin
			model_output[k] = '0;
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_passes();
		test_weight_access();
		test_directed_passes();
		send_idle = 26;
		take_idle = 72;
		test_random(300);
		set_rate(13'd4096);
		test_random(250);
		send_idle = 72;
		take_idle = 26;
		set_rate(13'd0);
		test_random(200);
		set_rate(13'h1fff);
		test_random(200);
		send_idle = 0;
		take_idle = 0;
		set_rate(13'd1);
		test_random(250);
		set_rate(13'(LR_RESET));
		test_random(300);
		drain();
		if (failures == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
